// ===== hw/rtl/spp_pkg.sv =====
// Shared types and constants for the spline path position block.
// Used by every module under hw/rtl; it depends on nothing else.
package spp_pkg;

  localparam int MAX_WP   = 64;
  localparam int AW       = 6;
  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int TW       = FB + 1;
  localparam int NW       = 7;
  localparam int ACCW     = 40;
  localparam int PRW      = ACCW + TW;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_CATROM = 1'b1;

  typedef struct packed {
    logic                 op;
    logic                 none;
    logic                 single;
    logic [AW-1:0]        idx;
    logic [NW-1:0]        n;
    logic [TW-1:0]        t;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fq_stat_t;

endpackage

// ===== hw/rtl/spp_front.sv =====
// Front end: classifies requests and maps a query parameter to segment and fraction.
// Depends on spp_pkg.
module spp_front (
  input  logic                         in_valid,
  input  logic                         in_kind,
  input  logic [spp_pkg::AW-1:0]       in_entry_index,
  input  logic signed [spp_pkg::CW-1:0] in_coord_x,
  input  logic signed [spp_pkg::CW-1:0] in_coord_y,
  input  logic signed [spp_pkg::CW-1:0] in_coord_z,
  input  logic [spp_pkg::TW-1:0]       in_param_s,
  input  logic [spp_pkg::NW-1:0]       count,
  input  spp_pkg::fq_stat_t            fq_stat,
  output logic                         in_stall,
  output logic                         push,
  output spp_pkg::qent_t               ent
);

  localparam logic [spp_pkg::TW-1:0] ONE_T = spp_pkg::TW'(1) << spp_pkg::FB;
  localparam int FW = spp_pkg::TW + spp_pkg::NW;

  logic [spp_pkg::NW-1:0] n;
  logic [spp_pkg::NW-1:0] nm1;
  logic [spp_pkg::TW-1:0] s_c;
  logic [FW-1:0]          f;
  logic [FW-spp_pkg::FB-1:0] seg_f;

  assign in_stall = fq_stat.full;
  assign push     = in_valid && !fq_stat.full;

  always_comb begin
    n     = (count > spp_pkg::NW'(spp_pkg::MAX_WP)) ? spp_pkg::NW'(spp_pkg::MAX_WP) : count;
    nm1   = n - spp_pkg::NW'(1);
    s_c   = (in_param_s > ONE_T) ? ONE_T : in_param_s;
    f     = FW'(s_c) * FW'(nm1);
    seg_f = f[FW-1:spp_pkg::FB];

    ent        = '0;
    ent.op     = in_kind;
    ent.n      = n;
    ent.x      = in_coord_x;
    ent.y      = in_coord_y;
    ent.z      = in_coord_z;
    ent.none   = (n == '0);
    ent.single = (n == spp_pkg::NW'(1));
    if (in_kind == spp_pkg::OP_WRITE) begin
      ent.idx = in_entry_index;
    end else if (n <= spp_pkg::NW'(1)) begin
      ent.idx = '0;
    end else if (seg_f >= (FW-spp_pkg::FB)'(nm1)) begin
      // The end of the path belongs to the last segment at full fraction.
      ent.idx = spp_pkg::AW'(n - spp_pkg::NW'(2));
      ent.t   = ONE_T;
    end else begin
      ent.idx = seg_f[spp_pkg::AW-1:0];
      ent.t   = {1'b0, f[spp_pkg::FB-1:0]};
    end
  end

endmodule

// ===== hw/rtl/spp_fifo.sv =====
// Four-entry request queue between front and back ends.
// Depends on spp_pkg.
module spp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spp_pkg::qent_t     wdata,
  input  logic               pop,
  output spp_pkg::qent_t     rdata,
  output spp_pkg::fq_stat_t  stat
);

  spp_pkg::qent_t mem_r [spp_pkg::FQ_DEPTH];
  logic [spp_pkg::FQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [spp_pkg::FQ_AW:0]   cnt_r, cnt_nxt;

  assign rdata      = mem_r[rp_r];
  assign stat.full  = (cnt_r == (spp_pkg::FQ_AW+1)'(spp_pkg::FQ_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wp_nxt  = wp_r + spp_pkg::FQ_AW'(push);
    rp_nxt  = rp_r + spp_pkg::FQ_AW'(pop);
    cnt_nxt = cnt_r + (spp_pkg::FQ_AW+1)'(push) - (spp_pkg::FQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/spp_back.sv =====
// Back end: waypoint memory, point fetch, Horner evaluation and result register.
// Depends on spp_pkg.
module spp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           mode,
  input  spp_pkg::fq_stat_t              fq_stat,
  input  spp_pkg::qent_t                 ent,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [spp_pkg::CW-1:0]  out_pos_x,
  output logic signed [spp_pkg::CW-1:0]  out_pos_y,
  output logic signed [spp_pkg::CW-1:0]  out_pos_z,
  output logic                           out_saturated
);

  localparam int CW   = spp_pkg::CW;
  localparam int ACCW = spp_pkg::ACCW;
  localparam int PRW  = spp_pkg::PRW;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [PRW-1:0] HALF = PRW'(1) << (spp_pkg::FB - 1);
  localparam logic signed [ACCW-1:0] CMAX = ACCW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [ACCW-1:0] CMIN = -CMAX - ACCW'(1);

  logic [3*CW-1:0] mem [spp_pkg::MAX_WP];
  logic [3*CW-1:0] rd_data_r;
  logic [spp_pkg::AW-1:0] rd_addr;

  logic [2:0] st_r, st_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] step_r, step_nxt;
  spp_pkg::qent_t cur_r;
  logic [1:0] pidx;

  logic signed [CW-1:0]   pt_r   [4][3];
  logic signed [ACCW-1:0] acc_r  [3];
  logic signed [ACCW-1:0] add_r  [3][3];
  logic [PRW-1:0]         prod_r [3];
  logic                   neg_r  [3];
  logic signed [CW-1:0]   res_r  [3];
  logic                   rsat_r;

  logic signed [ACCW-1:0] q0 [3], q3 [3], p1e [3], p2e [3];
  logic signed [ACCW-1:0] rnd [3], fin [3];
  logic [ACCW-1:0]        mag [3];
  logic [PRW-1:0]         rsum [3];
  logic [1:0]             last_step;
  logic                   out_free;

  assign pop       = (st_r == S_IDLE) && !fq_stat.empty;
  assign rd_addr   = cur_r.idx + {{(spp_pkg::AW-2){1'b0}}, cnt_r[1:0]}
                   - {{(spp_pkg::AW-1){1'b0}}, 1'b1};
  assign pidx      = cnt_r[1:0] - 2'd1;
  assign last_step = (mode == spp_pkg::MODE_CATROM) ? 2'd2 : 2'd0;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (pop && ent.op == spp_pkg::OP_WRITE) begin
      mem[ent.idx] <= {ent.x, ent.y, ent.z};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      p1e[l] = ACCW'(pt_r[1][l]);
      p2e[l] = ACCW'(pt_r[2][l]);
      // Missing neighbors at the path ends are reflected through the end point.
      q0[l]  = (cur_r.idx != '0) ? ACCW'(pt_r[0][l]) : (p1e[l] <<< 1) - p2e[l];
      q3[l]  = (({1'b0, cur_r.idx} + spp_pkg::NW'(2)) < cur_r.n) ? ACCW'(pt_r[3][l])
             : (p2e[l] <<< 1) - p1e[l];
      mag[l] = acc_r[l][ACCW-1] ? ACCW'(-acc_r[l]) : acc_r[l];
      rsum[l] = prod_r[l] + HALF;
      rnd[l]  = ACCW'(rsum[l] >> spp_pkg::FB);
      if (neg_r[l]) begin
        rnd[l] = -rnd[l];
      end
      if (mode == spp_pkg::MODE_LINEAR) begin
        fin[l] = acc_r[l];
      end else if (!acc_r[l][ACCW-1]) begin
        fin[l] = (acc_r[l] + ACCW'(1)) >>> 1;
      end else begin
        fin[l] = -((-acc_r[l] + ACCW'(1)) >>> 1);
      end
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    step_nxt = step_r;
    case (st_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (pop && ent.op == spp_pkg::OP_QUERY) begin
          st_nxt = ent.none ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          st_nxt = S_PREP;
        end
      end
      S_PREP: begin
        step_nxt = '0;
        st_nxt   = cur_r.single ? S_OUT : S_MUL;
      end
      S_MUL: st_nxt = S_ADD;
      S_ADD: begin
        step_nxt = step_r + 2'd1;
        st_nxt   = (step_r == last_step) ? S_FIN : S_MUL;
      end
      S_FIN: st_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      step_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      step_r <= step_nxt;
      if (st_r == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= ent;
      if (ent.none) begin
        for (int l = 0; l < 3; l++) res_r[l] <= '0;
        rsat_r <= 1'b0;
      end
    end
    if (st_r == S_READ && cnt_r != 3'd0) begin
      pt_r[pidx][0] <= rd_data_r[3*CW-1:2*CW];
      pt_r[pidx][1] <= rd_data_r[2*CW-1:CW];
      pt_r[pidx][2] <= rd_data_r[CW-1:0];
    end
    if (st_r == S_PREP) begin
      rsat_r <= 1'b0;
      for (int l = 0; l < 3; l++) begin
        res_r[l] <= pt_r[1][l];
        if (mode == spp_pkg::MODE_LINEAR) begin
          acc_r[l]    <= p2e[l] - p1e[l];
          add_r[l][0] <= p1e[l];
        end else begin
          acc_r[l]    <= -q0[l] + ACCW'(3) * p1e[l] - ACCW'(3) * p2e[l] + q3[l];
          add_r[l][0] <= (q0[l] <<< 1) - ACCW'(5) * p1e[l] + (p2e[l] <<< 2) - q3[l];
          add_r[l][1] <= p2e[l] - q0[l];
          add_r[l][2] <= p1e[l] <<< 1;
        end
      end
    end
    if (st_r == S_MUL) begin
      for (int l = 0; l < 3; l++) begin
        prod_r[l] <= PRW'(mag[l]) * PRW'(cur_r.t);
        neg_r[l]  <= acc_r[l][ACCW-1];
      end
    end
    if (st_r == S_ADD) begin
      for (int l = 0; l < 3; l++) begin
        acc_r[l] <= add_r[l][step_r] + rnd[l];
      end
    end
    if (st_r == S_FIN) begin
      for (int l = 0; l < 3; l++) begin
        if (fin[l] > CMAX) begin
          res_r[l] <= CW'(CMAX);
        end else if (fin[l] < CMIN) begin
          res_r[l] <= CW'(CMIN);
        end else begin
          res_r[l] <= fin[l][CW-1:0];
        end
      end
      rsat_r <= (fin[0] > CMAX) || (fin[0] < CMIN) || (fin[1] > CMAX) || (fin[1] < CMIN)
             || (fin[2] > CMAX) || (fin[2] < CMIN);
    end
    if (st_r == S_OUT && out_free) begin
      out_pos_x     <= res_r[0];
      out_pos_y     <= res_r[1];
      out_pos_z     <= res_r[2];
      out_saturated <= rsat_r;
    end
  end

endmodule

// ===== hw/rtl/spline_path_position.sv =====
// Top level of the spline path position block: configuration registers and the
// front end, request queue and back end. Depends on spp_pkg and the spp_ modules.
//
// Usage:
//   in_*  : request channel (valid/stall). in_kind 0 stores a waypoint at
//           in_entry_index, in_kind 1 queries the position at in_param_s.
//   out_* : one result per query (valid/stall), none per waypoint write.
//   cfg_* : register writes (valid/ready, ready always high); index 0 is the
//           interpolation mode, index 1 the waypoint count. Write while idle.
// Operation: the back end handles one request at a time. A write is popped from
// the queue and written to the memory at the same clock edge. A query reads four
// points through the single read port, then runs one multiply/add pass for linear
// mode or three for Catmull-Rom. A query with no waypoints skips the reads and the
// passes, and one with a single waypoint skips the passes. The back end does not
// take a new query before the last is through, and the four-entry queue lets the
// front keep taking requests meanwhile.
// Reset clears the queue, the control state and both registers; the waypoint
// memory is not cleared and must be written before it is read.
// A stall on out_ holds the result; the queue then fills and in_stall rises.
module spline_path_position (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [spp_pkg::AW-1:0]         in_entry_index,
  input  logic signed [spp_pkg::CW-1:0]  in_coord_x,
  input  logic signed [spp_pkg::CW-1:0]  in_coord_y,
  input  logic signed [spp_pkg::CW-1:0]  in_coord_z,
  input  logic [spp_pkg::TW-1:0]         in_param_s,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [spp_pkg::CW-1:0]  out_pos_x,
  output logic signed [spp_pkg::CW-1:0]  out_pos_y,
  output logic signed [spp_pkg::CW-1:0]  out_pos_z,
  output logic                           out_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [spp_pkg::NW-1:0]         cfg_data
);

  logic                   mode_r;
  logic [spp_pkg::NW-1:0] count_r;
  logic                   push, pop;
  spp_pkg::qent_t         went, rent;
  spp_pkg::fq_stat_t      fq_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= spp_pkg::MODE_LINEAR;
      count_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        spp_pkg::CFG_MODE:  mode_r  <= cfg_data[0];
        spp_pkg::CFG_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  spp_front u_front (
    .in_valid, .in_kind, .in_entry_index, .in_coord_x, .in_coord_y, .in_coord_z,
    .in_param_s, .count(count_r), .fq_stat, .in_stall, .push, .ent(went)
  );

  spp_fifo u_fifo (
    .clk, .rst_n, .push, .wdata(went), .pop, .rdata(rent), .stat(fq_stat)
  );

  spp_back u_back (
    .clk, .rst_n, .mode(mode_r), .fq_stat, .ent(rent), .pop,
    .out_valid, .out_stall, .out_pos_x, .out_pos_y, .out_pos_z, .out_saturated
  );

endmodule

// ===== hw/rtl/spp_checker.sv =====
// Port-level checks for spline_path_position, attached by the bind below.
// Depends on spp_pkg for widths.
module spp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [spp_pkg::CW-1:0] out_pos_x,
  input logic signed [spp_pkg::CW-1:0] out_pos_y,
  input logic signed [spp_pkg::CW-1:0] out_pos_z,
  input logic                          out_saturated
);

  localparam logic signed [spp_pkg::CW-1:0] CMAX = {1'b0, {(spp_pkg::CW-1){1'b1}}};
  localparam logic signed [spp_pkg::CW-1:0] CMIN = {1'b1, {(spp_pkg::CW-1){1'b0}}};

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pos_x) && $stable(out_pos_y)
                               && $stable(out_pos_z))
    else $error("stalled result changed");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_pos_x == CMAX || out_pos_x == CMIN
      || out_pos_y == CMAX || out_pos_y == CMIN || out_pos_z == CMAX || out_pos_z == CMIN)
    else $error("saturation flagged without a clipped coordinate");

endmodule

bind spline_path_position spp_checker u_spp_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_pos_x, .out_pos_y, .out_pos_z, .out_saturated
);
